// ===== hdl/chse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chse_pkg
// Types, constants and control words shared by the chained hash set engine.
// ----------------------------------------------------------------------------
package chse_pkg;

    localparam int DEF_NUM_BUCKETS  = 1024;
    localparam int DEF_POOL_ENTRIES = 4096;
    localparam int DEF_VALUE_WIDTH  = 40;

    localparam int HASH_MULT       = 104729;
    localparam int HASH_MULT_WIDTH = 17;

    localparam int BCOUNT_WIDTH = 11;
    localparam logic [BCOUNT_WIDTH-1:0] BCOUNT_RESET = 11'd1024;

    localparam int OPCODE_WIDTH = 2;
    localparam logic [OPCODE_WIDTH-1:0] OP_ADD   = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_DEL   = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_QUERY = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_LD,
        S_CHK,
        S_CMP,
        S_ACT,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_ALLOC_RD,
        S_ALLOC_POP,
        S_ADD_FILL,
        S_ADD_LINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic mod_step;
        logic head_rd;
        logic head_ld;
        logic ent_rd;
        logic advance;
        logic del_unlink;
        logic del_free;
        logic alloc_rd;
        logic alloc_pop;
        logic alloc_fresh;
        logic add_fill;
        logic add_link;
        logic res_set;
        logic res_hit;
        logic res_full;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] op;
        logic clr_last;
        logic mod_last;
        logic cur_null;
        logic match;
        logic free_null;
        logic fresh_avail;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/chse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chse_ctrl
// Sequencer for clear, hash, chain walk, update and result hand-off.
// ----------------------------------------------------------------------------
module chse_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire chse_pkg::dp_status_t status,
    output chse_pkg::ctrl_cmd_t       cmd,
    output logic                      in_stall
);

    chse_pkg::state_t state_reg;
    chse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chse_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chse_pkg::S_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = chse_pkg::S_IDLE;
                end
            end
            chse_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = chse_pkg::S_MOD;
                end
            end
            chse_pkg::S_MOD:
            begin
                if (status.mod_last)
                begin
                    state_next = chse_pkg::S_HEAD_RD;
                end
            end
            chse_pkg::S_HEAD_RD: state_next = chse_pkg::S_HEAD_LD;
            chse_pkg::S_HEAD_LD: state_next = chse_pkg::S_CHK;
            chse_pkg::S_CHK:
            begin
                state_next = status.cur_null ? chse_pkg::S_ACT : chse_pkg::S_CMP;
            end
            chse_pkg::S_CMP:
            begin
                state_next = status.match ? chse_pkg::S_ACT : chse_pkg::S_CHK;
            end
            chse_pkg::S_ACT:
            begin
                state_next = chse_pkg::S_DONE;
                if (status.op == chse_pkg::OP_ADD && status.cur_null)
                begin
                    if (!status.free_null)
                    begin
                        state_next = chse_pkg::S_ALLOC_RD;
                    end
                    else if (status.fresh_avail)
                    begin
                        state_next = chse_pkg::S_ADD_FILL;
                    end
                end
                else if (status.op == chse_pkg::OP_DEL && !status.cur_null)
                begin
                    state_next = chse_pkg::S_DEL_UNLINK;
                end
            end
            chse_pkg::S_DEL_UNLINK: state_next = chse_pkg::S_DEL_FREE;
            chse_pkg::S_DEL_FREE:   state_next = chse_pkg::S_DONE;
            chse_pkg::S_ALLOC_RD:   state_next = chse_pkg::S_ALLOC_POP;
            chse_pkg::S_ALLOC_POP:  state_next = chse_pkg::S_ADD_FILL;
            chse_pkg::S_ADD_FILL:   state_next = chse_pkg::S_ADD_LINK;
            chse_pkg::S_ADD_LINK:   state_next = chse_pkg::S_DONE;
            chse_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = chse_pkg::S_IDLE;
                end
            end
            default: state_next = chse_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            chse_pkg::S_CLEAR: cmd.clr_step = 1'b1;
            chse_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            chse_pkg::S_MOD:     cmd.mod_step = 1'b1;
            chse_pkg::S_HEAD_RD: cmd.head_rd  = 1'b1;
            chse_pkg::S_HEAD_LD: cmd.head_ld  = 1'b1;
            chse_pkg::S_CHK:     cmd.ent_rd   = !status.cur_null;
            chse_pkg::S_CMP:     cmd.advance  = !status.match;
            chse_pkg::S_ACT:
            begin
                cmd.res_set = 1'b1;
                case (status.op)
                    chse_pkg::OP_ADD:
                    begin
                        cmd.alloc_fresh = status.cur_null && status.free_null
                                          && status.fresh_avail;
                        cmd.res_full    = status.cur_null && status.free_null
                                          && !status.fresh_avail;
                    end
                    chse_pkg::OP_QUERY: cmd.res_hit = !status.cur_null;
                    default:            cmd.res_hit = 1'b0;
                endcase
            end
            chse_pkg::S_DEL_UNLINK: cmd.del_unlink = 1'b1;
            chse_pkg::S_DEL_FREE:
            begin
                cmd.del_free = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_hit  = 1'b1;
            end
            chse_pkg::S_ALLOC_RD:  cmd.alloc_rd  = 1'b1;
            chse_pkg::S_ALLOC_POP: cmd.alloc_pop = 1'b1;
            chse_pkg::S_ADD_FILL:  cmd.add_fill  = 1'b1;
            chse_pkg::S_ADD_LINK:
            begin
                cmd.add_link = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_hit  = 1'b1;
            end
            chse_pkg::S_DONE: cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/chse_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chse_datapath
// Hash multiply, bit-serial modulo, bucket head memory, entry pool memories,
// free list and result register.
// ----------------------------------------------------------------------------
module chse_datapath #(
    parameter int NUM_BUCKETS  = chse_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_ENTRIES = chse_pkg::DEF_POOL_ENTRIES,
    parameter int VALUE_WIDTH  = chse_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire chse_pkg::ctrl_cmd_t                 cmd,
    output chse_pkg::dp_status_t                     status,
    input  wire logic                                cfg_wr_en,
    input  wire logic [chse_pkg::BCOUNT_WIDTH-1:0]   cfg_wr_data,
    input  wire logic [chse_pkg::OPCODE_WIDTH-1:0]   opcode,
    input  wire logic [VALUE_WIDTH-1:0]              op_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     hit_or_changed,
    output logic                                     pool_full
);

    localparam int BIW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int IW  = $clog2(POOL_ENTRIES);
    localparam int LW  = $clog2(POOL_ENTRIES + 1);
    localparam int PW  = VALUE_WIDTH + chse_pkg::HASH_MULT_WIDTH;
    localparam int CW  = $clog2(PW);
    localparam int NW  = chse_pkg::BCOUNT_WIDTH;
    localparam logic [LW-1:0]  NULL_LINK = LW'(POOL_ENTRIES);
    localparam logic [BIW-1:0] LAST_BKT  = BIW'(NUM_BUCKETS - 1);

    logic [NW-1:0]          bcount_reg;
    logic [BIW-1:0]         clr_reg;
    logic [chse_pkg::OPCODE_WIDTH-1:0] op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [PW-1:0]          prod_reg;
    logic [CW-1:0]          cnt_reg;
    logic [NW-1:0]          rem_reg;
    logic [LW-1:0]          cur_reg;
    logic [LW-1:0]          prev_reg;
    logic [LW-1:0]          new_reg;
    logic [LW-1:0]          free_reg;
    logic [LW-1:0]          fresh_reg;
    logic                   res_hit_reg;
    logic                   res_full_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic                   out_full_reg;

    logic [LW-1:0]          head_mem [NUM_BUCKETS];
    logic [VALUE_WIDTH-1:0] val_mem  [POOL_ENTRIES];
    logic [LW-1:0]          link_mem [POOL_ENTRIES];
    logic [LW-1:0]          head_q;
    logic [VALUE_WIDTH-1:0] val_q;
    logic [LW-1:0]          link_q;

    logic [31:0]   bc_wide;
    logic [NW-1:0] n_eff;
    logic [NW:0]   mod_trial;
    logic [NW-1:0] rem_next;
    logic [16:0]   rem_wide;
    logic [BIW-1:0] bkt;
    logic          prev_null;

    logic           head_we;
    logic [BIW-1:0] head_wa;
    logic [LW-1:0]  head_wd;
    logic           link_we;
    logic [IW-1:0]  link_wa;
    logic [LW-1:0]  link_wd;
    logic [IW-1:0]  link_ra;

    assign bc_wide = 32'(bcount_reg);
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (bc_wide > 32'(NUM_BUCKETS))
        begin
            n_eff = NW'(NUM_BUCKETS);
        end
        else
        begin
            n_eff = bcount_reg;
        end
    end

    assign mod_trial = {rem_reg, prod_reg[PW-1]};
    assign rem_next  = (mod_trial >= {1'b0, n_eff}) ? NW'(mod_trial - {1'b0, n_eff})
                                                    : mod_trial[NW-1:0];
    assign rem_wide  = 17'(rem_reg);
    assign bkt       = rem_wide[BIW-1:0];
    assign prev_null = (prev_reg == NULL_LINK);

    always_comb
    begin
        head_we = 1'b0;
        head_wa = bkt;
        head_wd = NULL_LINK;
        if (cmd.clr_step)
        begin
            head_we = 1'b1;
            head_wa = clr_reg;
        end
        else if (cmd.add_link && prev_null)
        begin
            head_we = 1'b1;
            head_wd = new_reg;
        end
        else if (cmd.del_unlink && prev_null)
        begin
            head_we = 1'b1;
            head_wd = link_q;
        end
    end

    always_comb
    begin
        link_we = 1'b0;
        link_wa = cur_reg[IW-1:0];
        link_wd = NULL_LINK;
        if (cmd.add_fill)
        begin
            link_we = 1'b1;
            link_wa = new_reg[IW-1:0];
        end
        else if (cmd.add_link && !prev_null)
        begin
            link_we = 1'b1;
            link_wa = prev_reg[IW-1:0];
            link_wd = new_reg;
        end
        else if (cmd.del_unlink && !prev_null)
        begin
            link_we = 1'b1;
            link_wa = prev_reg[IW-1:0];
            link_wd = link_q;
        end
        else if (cmd.del_free)
        begin
            link_we = 1'b1;
            link_wd = free_reg;
        end
    end

    assign link_ra = cmd.alloc_rd ? free_reg[IW-1:0] : cur_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (cmd.head_rd)
        begin
            head_q <= head_mem[bkt];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_fill)
        begin
            val_mem[new_reg[IW-1:0]] <= val_reg;
        end
        if (cmd.ent_rd)
        begin
            val_q <= val_mem[cur_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.ent_rd || cmd.alloc_rd)
        begin
            link_q <= link_mem[link_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= opcode;
            val_reg  <= op_value;
            prod_reg <= PW'(op_value) * PW'(chse_pkg::HASH_MULT);
        end
        else if (cmd.mod_step)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
        end
        if (cmd.load_in)
        begin
            cnt_reg <= CW'(PW - 1);
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            rem_reg <= rem_next;
        end
        if (cmd.head_ld)
        begin
            cur_reg  <= head_q;
            prev_reg <= NULL_LINK;
        end
        else if (cmd.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= link_q;
        end
        if (cmd.alloc_pop)
        begin
            new_reg <= free_reg;
        end
        else if (cmd.alloc_fresh)
        begin
            new_reg <= fresh_reg;
        end
        if (cmd.res_set)
        begin
            res_hit_reg  <= cmd.res_hit;
            res_full_reg <= cmd.res_full;
        end
        if (cmd.out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_full_reg <= res_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg    <= chse_pkg::BCOUNT_RESET;
            clr_reg       <= '0;
            free_reg      <= NULL_LINK;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bcount_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + BIW'(1);
            end
            if (cmd.alloc_pop)
            begin
                free_reg <= link_q;
            end
            else if (cmd.del_free)
            begin
                free_reg <= cur_reg;
            end
            if (cmd.alloc_fresh)
            begin
                fresh_reg <= fresh_reg + LW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.op          = op_reg;
    assign status.clr_last    = (clr_reg == LAST_BKT);
    assign status.mod_last    = (cnt_reg == '0);
    assign status.cur_null    = (cur_reg == NULL_LINK);
    assign status.match       = (val_q == val_reg);
    assign status.free_null   = (free_reg == NULL_LINK);
    assign status.fresh_avail = (fresh_reg < NULL_LINK);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign hit_or_changed = out_hit_reg;
    assign pool_full      = out_full_reg;

endmodule
`default_nettype wire

// ===== hdl/chained_hash_set_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_set_engine_top
// Hash set with separate chaining over a fixed entry pool and a free list.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  opcode, op_value
//   out      source     out_valid/out_stall  hit_or_changed, pool_full
//   cfg      sink       cfg_wr_en            cfg_wr_data (bucket count)
//
// An item passes through a bit-serial modulo of the VALUE_WIDTH + 17 bit
// hash product, a bucket head read, a walk along the chain that compares
// each entry visited, and an update and result hand-off before the next
// item is accepted. After reset a clearing pass writes NUM_BUCKETS bucket
// heads, one a cycle, with in_stall high. A finished result waits in the
// output register while the next item is accepted and worked on; hold the
// hand-off while it stalls.
// ----------------------------------------------------------------------------
module chained_hash_set_engine_top #(
    parameter int NUM_BUCKETS  = chse_pkg::DEF_NUM_BUCKETS,
    parameter int POOL_ENTRIES = chse_pkg::DEF_POOL_ENTRIES,
    parameter int VALUE_WIDTH  = chse_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [chse_pkg::BCOUNT_WIDTH-1:0] cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [chse_pkg::OPCODE_WIDTH-1:0] opcode,
    input  wire logic [VALUE_WIDTH-1:0]            op_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit_or_changed,
    output logic                                   pool_full
);

    chse_pkg::ctrl_cmd_t  cmd;
    chse_pkg::dp_status_t status;

    chse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    chse_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .opcode         (opcode),
        .op_value       (op_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_or_changed (hit_or_changed),
        .pool_full      (pool_full)
    );

endmodule
`default_nettype wire

// ===== hdl/chse_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chse_checker
// Port-level checks on the hash set engine, bound to the top level.
// ----------------------------------------------------------------------------
module chse_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic hit_or_changed,
    input wire logic pool_full
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_or_changed)
                                   && $stable(pool_full))
        else $error("stalled result changed");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pool_full && hit_or_changed))
        else $error("pool_full with hit_or_changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item in work");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared right after accept");

endmodule

bind chained_hash_set_engine_top chse_checker u_chse_checker (.*);
`default_nettype wire

// ===== tb/chained_hash_set_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_set_engine_top_tb
// Self-checking bench for the chained hash set engine. Add, delete, query and
// unused-opcode items are checked against an in-bench copy of the table,
// under several bucket counts, with random gaps on both channels and a long
// output hold-off.
// ----------------------------------------------------------------------------
module chained_hash_set_engine_top_tb;

    localparam int NBUCKETS  = chse_pkg::DEF_NUM_BUCKETS;
    localparam int NENTRIES  = chse_pkg::DEF_POOL_ENTRIES;
    localparam int VW        = chse_pkg::DEF_VALUE_WIDTH;
    localparam int NULL_LINK = NENTRIES;
    localparam logic [chse_pkg::OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 400;

    typedef enum int {SEND_BUSY, RECV_BUSY, NO_GAPS} gap_mode_t;

    typedef struct {
        logic [chse_pkg::OPCODE_WIDTH-1:0] op;
        logic [VW-1:0]                     val;
    } set_op_t;

    typedef struct {
        logic hit;
        logic full;
    } set_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [chse_pkg::BCOUNT_WIDTH-1:0] cfg_wr_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [chse_pkg::OPCODE_WIDTH-1:0] opcode;
    logic [VW-1:0]                     op_value;
    logic                              out_valid;
    logic                              out_stall;
    logic                              hit_or_changed;
    logic                              pool_full;

    set_op_t     pending_ops[$];
    set_result_t expected_results[$];
    gap_mode_t   gap_mode;
    int          error_count;
    longint      cycle_count;
    logic        hold_req;
    logic        hold_started;
    int          hold_cnt;

    // table copy
    int            heads[NBUCKETS];
    logic [VW-1:0] ent_val[NENTRIES];
    int            ent_link[NENTRIES];
    int            free_head;
    int            fresh_cnt;
    logic [chse_pkg::BCOUNT_WIDTH-1:0] bucket_cnt;
    logic [VW-1:0] work_set[32];

    chained_hash_set_engine_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .op_value       (op_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_or_changed (hit_or_changed),
        .pool_full      (pool_full)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic set_result_t apply_set_op(set_op_t item);
        set_result_t r;
        longint unsigned n;
        int b;
        int prev;
        int cur;
        int steps;
        int e;
        int nxt;
        logic found;
        r.hit = 1'b0;
        r.full = 1'b0;
        n = bucket_cnt;
        if (n == 0) n = 1;
        if (n > NBUCKETS) n = NBUCKETS;
        b = int'((64'(item.val) * 64'(chse_pkg::HASH_MULT)) % n);
        prev = NULL_LINK;
        cur = heads[b];
        steps = 0;
        while (cur < NULL_LINK && steps < NENTRIES && ent_val[cur] != item.val)
        begin
            prev = cur;
            cur = ent_link[cur];
            steps++;
        end
        found = (cur < NULL_LINK) && (ent_val[cur] == item.val);
        if (item.op == chse_pkg::OP_ADD && !found)
        begin
            e = NULL_LINK;
            if (free_head < NULL_LINK)
            begin
                e = free_head;
                free_head = ent_link[e];
            end
            else if (fresh_cnt < NENTRIES)
            begin
                e = fresh_cnt;
                fresh_cnt++;
            end
            if (e < NULL_LINK)
            begin
                ent_val[e] = item.val;
                ent_link[e] = NULL_LINK;
                if (prev < NULL_LINK) ent_link[prev] = e;
                else heads[b] = e;
                r.hit = 1'b1;
            end
            else
            begin
                r.full = 1'b1;
            end
        end
        else if (item.op == chse_pkg::OP_DEL && found)
        begin
            nxt = ent_link[cur];
            if (prev < NULL_LINK) ent_link[prev] = nxt;
            else heads[b] = nxt;
            ent_link[cur] = free_head;
            free_head = cur;
            r.hit = 1'b1;
        end
        else if (item.op == chse_pkg::OP_QUERY)
        begin
            r.hit = found;
        end
        return r;
    endfunction

    task automatic queue_op(logic [chse_pkg::OPCODE_WIDTH-1:0] op, logic [VW-1:0] val);
        set_op_t item;
        item.op = op;
        item.val = val;
        expected_results.push_back(apply_set_op(item));
        pending_ops.push_back(item);
    endtask

    task automatic drain_and_settle();
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bucket_count(logic [chse_pkg::BCOUNT_WIDTH-1:0] cnt);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cnt;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bucket_cnt = cnt;
    endtask

    task automatic random_ops(int count, int set_size);
        int k;
        int roll;
        logic [chse_pkg::OPCODE_WIDTH-1:0] op;
        logic [VW-1:0] val;
        for (k = 0; k < 32; k++)
        begin
            if (k % 3 == 0) work_set[k] = VW'($urandom_range(0, 4095));
            else work_set[k] = {8'($urandom) & 8'h7F, 32'($urandom)};
        end
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40) op = chse_pkg::OP_ADD;
            else if (roll < 70) op = chse_pkg::OP_DEL;
            else if (roll < 95) op = chse_pkg::OP_QUERY;
            else op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0) val = {8'($urandom), 32'($urandom)};
            else val = work_set[$urandom_range(0, set_size - 1)];
            queue_op(op, val);
        end
    endtask

    initial
    begin
        int i;
        logic [VW-1:0] vmax;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        hold_req = 1'b0;
        error_count = 0;
        gap_mode = NO_GAPS;
        bucket_cnt = chse_pkg::BCOUNT_RESET;
        for (i = 0; i < NBUCKETS; i++) heads[i] = NULL_LINK;
        for (i = 0; i < NENTRIES; i++)
        begin
            ent_val[i] = '0;
            ent_link[i] = 0;
        end
        free_head = NULL_LINK;
        fresh_cnt = 0;
        vmax = '1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_op(chse_pkg::OP_ADD, '0);
        queue_op(chse_pkg::OP_ADD, vmax);
        queue_op(chse_pkg::OP_ADD, '0);
        queue_op(chse_pkg::OP_QUERY, '0);
        queue_op(chse_pkg::OP_QUERY, vmax);
        queue_op(chse_pkg::OP_DEL, '0);
        queue_op(chse_pkg::OP_DEL, '0);
        queue_op(chse_pkg::OP_QUERY, '0);
        queue_op(OP_UNUSED, vmax);
        queue_op(OP_UNUSED, '0);
        queue_op(chse_pkg::OP_ADD, 40'd5);
        queue_op(chse_pkg::OP_ADD, 40'd5 + 40'd1024);
        queue_op(chse_pkg::OP_ADD, 40'd5 + 40'd2048);
        queue_op(chse_pkg::OP_QUERY, 40'd5 + 40'd2048);
        queue_op(chse_pkg::OP_DEL, 40'd5 + 40'd1024);
        queue_op(chse_pkg::OP_QUERY, 40'd5 + 40'd2048);
        queue_op(chse_pkg::OP_QUERY, 40'd5 + 40'd1024);
        queue_op(chse_pkg::OP_DEL, 40'd5);
        queue_op(chse_pkg::OP_QUERY, 40'd5 + 40'd2048);
        queue_op(chse_pkg::OP_ADD, 40'd7);
        queue_op(chse_pkg::OP_ADD, 40'd5);
        queue_op(chse_pkg::OP_DEL, vmax);
        queue_op(chse_pkg::OP_QUERY, vmax);
        drain_and_settle();

        gap_mode = SEND_BUSY;
        write_bucket_count(11'd1024);
        random_ops(500, 32);
        hold_req = 1'b1;
        drain_and_settle();

        gap_mode = RECV_BUSY;
        write_bucket_count(11'd0);
        random_ops(300, 20);
        drain_and_settle();

        gap_mode = NO_GAPS;
        write_bucket_count(11'd2047);
        random_ops(300, 32);
        drain_and_settle();

        gap_mode = SEND_BUSY;
        write_bucket_count(11'd1);
        random_ops(200, 16);
        drain_and_settle();

        gap_mode = RECV_BUSY;
        write_bucket_count(chse_pkg::BCOUNT_WIDTH'($urandom_range(2, 1023)));
        random_ops(310, 32);
        drain_and_settle();

        gap_mode = NO_GAPS;
        write_bucket_count(11'd1024);
        for (i = 0; i < 40; i++)
            queue_op(chse_pkg::OP_ADD, 40'hF0_0000_0000 + VW'(i));
        queue_op(chse_pkg::OP_ADD, 40'hF0_0000_0000);
        for (i = 0; i < 10; i++)
        begin
            queue_op(chse_pkg::OP_DEL, 40'hF0_0000_0000 + VW'(i * 7));
            queue_op(chse_pkg::OP_QUERY, 40'hF0_0000_0000 + VW'(i * 7));
        end
        for (i = 0; i < 12; i++)
            queue_op(chse_pkg::OP_ADD, 40'hE0_0000_0000 + VW'(i));
        random_ops(100, 32);
        drain_and_settle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            op_value <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_ops.size() != 0 &&
                !(gap_mode == SEND_BUSY && $urandom_range(0, 99) < 12) &&
                !(gap_mode == RECV_BUSY && $urandom_range(0, 99) < 71))
            begin
                in_valid <= 1'b1;
                opcode <= pending_ops[0].op;
                op_value <= pending_ops[0].val;
                pending_ops.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_started <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_req && !hold_started && pending_ops.size() > 50)
        begin
            hold_started <= 1'b1;
            hold_cnt <= 3000;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result hit_or_changed=%0b pool_full=%0b",
                           hit_or_changed, pool_full);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (hit_or_changed !== want.hit)
                    begin
                        $error("hit_or_changed expected %0b actual %0b",
                               want.hit, hit_or_changed);
                        error_count++;
                    end
                    if (pool_full !== want.full)
                    begin
                        $error("pool_full expected %0b actual %0b", want.full, pool_full);
                        error_count++;
                    end
                end
            end
            out_stall <= (hold_cnt > 1) ||
                         (gap_mode == SEND_BUSY && $urandom_range(0, 99) < 71) ||
                         (gap_mode == RECV_BUSY && $urandom_range(0, 99) < 12);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
